@@ rtl/lode_pkg.sv @@
// Shared constants, command codes and control structs for the linear ODE Euler stepper.
package lode_pkg;

    // Defaults and fixed sizes
    localparam int ORDER_DEFAULT = 4;
    localparam int NUM_ELEM      = 4;
    localparam int Q_W           = 32;
    localparam int S_DATA_W      = 40;
    localparam int M_DATA_W      = 72;
    localparam int RES_W         = 66;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_BITS      = 48;
    localparam int DIV_CNT_W     = $clog2(DIV_BITS);

    // Register reset values (signed Q16.16)
    localparam logic signed [Q_W-1:0] STEP_SIZE_RST = 32'sd6554;
    localparam logic signed [Q_W-1:0] COEFF_TOP_RST = 32'sd65536;

    // Input operation codes
    localparam logic [1:0] OP_LOAD_ELEM = 2'd0;
    localparam logic [1:0] OP_LOAD_X    = 2'd1;
    localparam logic [1:0] OP_STEP      = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SAT      = 2'd1;
    localparam logic [1:0] ST_TOP_ZERO = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP   = 3'd5;

    // Datapath command codes
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LOAD_ELEM = 4'd1;
    localparam logic [3:0] CMD_LOAD_X    = 4'd2;
    localparam logic [3:0] CMD_START     = 4'd3;
    localparam logic [3:0] CMD_DOT_MUL   = 4'd4;
    localparam logic [3:0] CMD_DOT_ACC   = 4'd5;
    localparam logic [3:0] CMD_DIV_INIT  = 4'd6;
    localparam logic [3:0] CMD_DIV_STEP  = 4'd7;
    localparam logic [3:0] CMD_DIV_END   = 4'd8;
    localparam logic [3:0] CMD_LOW_MUL   = 4'd9;
    localparam logic [3:0] CMD_LOW_UPD   = 4'd10;
    localparam logic [3:0] CMD_TOP_MUL   = 4'd11;
    localparam logic [3:0] CMD_TOP_UPD   = 4'd12;
    localparam logic [3:0] CMD_FINISH    = 4'd13;

    typedef struct packed {
        logic [3:0] code;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic top_zero;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/lode_dp.sv @@
// Datapath: config registers, state, shared multiplier, serial divider, output register.
module lode_dp
    import lode_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data,
    input  logic [1:0]           element_index,
    input  logic [Q_W-1:0]       load_value,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RES_W-1:0]     out_data
);

    typedef struct packed {
        logic           ovf;
        logic [Q_W-1:0] val;
    } sat_t;

    localparam logic signed [49:0] QMAX50 = 50'sd2147483647;
    localparam logic signed [49:0] QMIN50 = -50'sd2147483648;
    localparam logic [1:0]         TOP_IDX = 2'(ORDER - 1);

    // Clamp a wide signed value to Q16.16 range
    function automatic sat_t sat_q(input logic signed [49:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[Q_W-1:0];
        if (v > QMAX50)
        begin
            r.ovf = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end
        else if (v < QMIN50)
        begin
            r.ovf = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

    // Control and architectural state
    logic signed [Q_W-1:0] step_reg, step_next;
    logic signed [Q_W-1:0] coeff_reg [NUM_ELEM];
    logic signed [Q_W-1:0] coeff_next [NUM_ELEM];
    logic signed [Q_W-1:0] top_reg, top_next;
    logic signed [Q_W-1:0] elem_reg [NUM_ELEM];
    logic signed [Q_W-1:0] elem_next [NUM_ELEM];
    logic signed [Q_W-1:0] x_reg, x_next;
    logic                  sat_reg, sat_next;
    logic                  top_zero_reg, top_zero_next;
    logic                  out_valid_reg, out_valid_next;

    // Working payload
    logic signed [63:0]    prod_reg, prod_next;
    logic signed [49:0]    acc_reg, acc_next;
    logic signed [Q_W-1:0] quot_reg, quot_next;
    logic [32:0]           rem_reg, rem_next;
    logic [DIV_BITS-1:0]   dvd_reg, dvd_next;
    logic [Q_W-1:0]        dsr_reg, dsr_next;
    logic                  qneg_reg, qneg_next;
    logic [Q_W-1:0]        x_old_reg, x_old_next;
    logic [Q_W-1:0]        y_old_reg, y_old_next;
    logic [RES_W-1:0]      out_data_reg, out_data_next;

    // Combinational helpers
    logic signed [Q_W-1:0] mul_a, mul_b;
    logic signed [47:0]    prod_q;
    sat_t                  inc_s, upd_s, acc_s, x_s;
    logic [1:0]            upd_idx;
    logic [Q_W-1:0]        a_mag, top_mag;
    logic [32:0]           rem_sh;
    logic                  rem_ge;
    logic                  ovf_all;
    logic [1:0]            status;

    // Multiplier operand select
    always_comb
    begin
        mul_a = step_reg;
        mul_b = quot_reg;
        unique case (cmd.code)
            CMD_DOT_MUL:
            begin
                mul_a = coeff_reg[cmd.idx];
                mul_b = elem_reg[cmd.idx];
            end
            CMD_LOW_MUL:
            begin
                mul_b = elem_reg[2'(cmd.idx + 2'd1)];
            end
            default:
            begin
                mul_b = quot_reg;
            end
        endcase
    end

    // Shared arithmetic terms
    always_comb
    begin
        prod_q  = prod_reg[63:16];
        inc_s   = sat_q({{2{prod_q[47]}}, prod_q});
        upd_idx = (cmd.code == CMD_TOP_UPD) ? TOP_IDX : cmd.idx;
        upd_s   = sat_q(50'(elem_reg[upd_idx]) + 50'($signed(inc_s.val)));
        acc_s   = sat_q(acc_reg);
        x_s     = sat_q(50'(x_reg) + 50'(step_reg));
        a_mag   = acc_s.val[Q_W-1] ? 32'(-acc_s.val) : acc_s.val;
        top_mag = top_reg[Q_W-1] ? 32'(-top_reg) : top_reg;
        rem_sh  = {rem_reg[31:0], dvd_reg[DIV_BITS-1]};
        rem_ge  = rem_sh >= {1'b0, dsr_reg};
        ovf_all = sat_reg | (x_s.ovf & ~top_zero_reg);
        if (top_zero_reg)
            status = ST_TOP_ZERO;
        else if (ovf_all)
            status = ST_SAT;
        else
            status = ST_OK;
    end

    // Next-state logic
    always_comb
    begin
        step_next      = step_reg;
        coeff_next     = coeff_reg;
        top_next       = top_reg;
        elem_next      = elem_reg;
        x_next         = x_reg;
        sat_next       = sat_reg;
        top_zero_next  = top_zero_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        qneg_next      = qneg_reg;
        x_old_next     = x_old_reg;
        y_old_next     = y_old_reg;
        out_data_next  = out_data_reg;

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:   step_next     = cfg_data;
                REG_COEFF_ZERO:  coeff_next[0] = cfg_data;
                REG_COEFF_ONE:   coeff_next[1] = cfg_data;
                REG_COEFF_TWO:   coeff_next[2] = cfg_data;
                REG_COEFF_THREE: coeff_next[3] = cfg_data;
                REG_COEFF_TOP:   top_next      = cfg_data;
                default:         step_next     = step_reg;
            endcase
        end

        unique case (cmd.code)
            CMD_LOAD_ELEM:
            begin
                if ({1'b0, element_index} < 3'(ORDER))
                    elem_next[element_index] = load_value;
            end
            CMD_LOAD_X:
            begin
                x_next = load_value;
            end
            CMD_START:
            begin
                x_old_next    = x_reg;
                y_old_next    = elem_reg[0];
                acc_next      = '0;
                sat_next      = 1'b0;
                top_zero_next = (top_reg == '0);
            end
            CMD_DOT_MUL, CMD_LOW_MUL, CMD_TOP_MUL:
            begin
                prod_next = mul_a * mul_b;
            end
            CMD_DOT_ACC:
            begin
                acc_next = acc_reg + {{2{prod_q[47]}}, prod_q};
            end
            CMD_DIV_INIT:
            begin
                sat_next  = sat_reg | acc_s.ovf;
                dvd_next  = {a_mag, 16'd0};
                rem_next  = '0;
                dsr_next  = top_mag;
                qneg_next = acc_s.val[Q_W-1] ^ ~top_reg[Q_W-1];
            end
            CMD_DIV_STEP:
            begin
                rem_next = rem_ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
                dvd_next = {dvd_reg[DIV_BITS-2:0], rem_ge};
            end
            CMD_DIV_END:
            begin
                if (!qneg_reg)
                begin
                    if (dvd_reg > 48'h0000_7FFF_FFFF)
                    begin
                        quot_next = 32'h7FFF_FFFF;
                        sat_next  = 1'b1;
                    end
                    else
                        quot_next = dvd_reg[Q_W-1:0];
                end
                else
                begin
                    if (dvd_reg > 48'h0000_8000_0000)
                    begin
                        quot_next = 32'h8000_0000;
                        sat_next  = 1'b1;
                    end
                    else
                        quot_next = 32'(-dvd_reg[Q_W-1:0]);
                end
            end
            CMD_LOW_UPD, CMD_TOP_UPD:
            begin
                elem_next[upd_idx] = upd_s.val;
                sat_next           = sat_reg | inc_s.ovf | upd_s.ovf;
            end
            CMD_FINISH:
            begin
                x_next         = x_s.val;
                out_valid_next = 1'b1;
                out_data_next  = {status, y_old_reg, x_old_reg};
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_SIZE_RST;
            top_reg       <= COEFF_TOP_RST;
            x_reg         <= '0;
            sat_reg       <= 1'b0;
            top_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                coeff_reg[i] <= '0;
                elem_reg[i]  <= '0;
            end
        end
        else
        begin
            step_reg      <= step_next;
            top_reg       <= top_next;
            x_reg         <= x_next;
            sat_reg       <= sat_next;
            top_zero_reg  <= top_zero_next;
            out_valid_reg <= out_valid_next;
            coeff_reg     <= coeff_next;
            elem_reg      <= elem_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        dsr_reg      <= dsr_next;
        qneg_reg     <= qneg_next;
        x_old_reg    <= x_old_next;
        y_old_reg    <= y_old_next;
        out_data_reg <= out_data_next;
    end

    assign stat.top_zero = (top_reg == '0);
    assign stat.out_free = ~out_valid_reg | out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

@@ rtl/lode_ctrl.sv @@
// Controller: sequences loads, dot product, division and element updates.
module lode_ctrl
    import lode_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DOT_MUL  = 4'd1;
    localparam logic [3:0] S_DOT_ACC  = 4'd2;
    localparam logic [3:0] S_DIV_INIT = 4'd3;
    localparam logic [3:0] S_DIV_STEP = 4'd4;
    localparam logic [3:0] S_DIV_END  = 4'd5;
    localparam logic [3:0] S_LOW_MUL  = 4'd6;
    localparam logic [3:0] S_LOW_UPD  = 4'd7;
    localparam logic [3:0] S_TOP_MUL  = 4'd8;
    localparam logic [3:0] S_TOP_UPD  = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    localparam logic [1:0]           LAST_DOT = 2'(ORDER - 1);
    localparam logic [1:0]           LAST_LOW = (ORDER > 1) ? 2'(ORDER - 2) : 2'd0;
    localparam logic [DIV_CNT_W-1:0] LAST_DIV = DIV_CNT_W'(DIV_BITS - 1);

    logic [3:0]           state_reg, state_next;
    logic [1:0]           idx_reg, idx_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cmd.code   = CMD_NONE;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        OP_LOAD_ELEM: cmd.code = CMD_LOAD_ELEM;
                        OP_LOAD_X:    cmd.code = CMD_LOAD_X;
                        OP_STEP:
                        begin
                            cmd.code   = CMD_START;
                            idx_next   = 2'd0;
                            state_next = stat.top_zero ? S_FINISH : S_DOT_MUL;
                        end
                        default:      cmd.code = CMD_NONE;
                    endcase
                end
            end
            S_DOT_MUL:
            begin
                cmd.code   = CMD_DOT_MUL;
                state_next = S_DOT_ACC;
            end
            S_DOT_ACC:
            begin
                cmd.code = CMD_DOT_ACC;
                if (idx_reg == LAST_DOT)
                    state_next = S_DIV_INIT;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_DOT_MUL;
                end
            end
            S_DIV_INIT:
            begin
                cmd.code   = CMD_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.code = CMD_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIV)
                    state_next = S_DIV_END;
            end
            S_DIV_END:
            begin
                cmd.code   = CMD_DIV_END;
                idx_next   = 2'd0;
                state_next = (ORDER > 1) ? S_LOW_MUL : S_TOP_MUL;
            end
            S_LOW_MUL:
            begin
                cmd.code   = CMD_LOW_MUL;
                state_next = S_LOW_UPD;
            end
            S_LOW_UPD:
            begin
                cmd.code = CMD_LOW_UPD;
                if (idx_reg == LAST_LOW)
                    state_next = S_TOP_MUL;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_LOW_MUL;
                end
            end
            S_TOP_MUL:
            begin
                cmd.code   = CMD_TOP_MUL;
                state_next = S_TOP_UPD;
            end
            S_TOP_UPD:
            begin
                cmd.code   = CMD_TOP_UPD;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.code   = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // A step with a usable divisor starts the dot product next
    a_step_starts_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && operation == OP_STEP && !stat.top_zero)
        |=> (state_reg == S_DOT_MUL))
        else $error("step did not start dot product");

    // Divider finishes only after its last iteration
    a_div_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_END) |-> ($past(state_reg) == S_DIV_STEP && $past(cnt_reg) == LAST_DIV))
        else $error("divider ended early");

    // Result only written into a free output register
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_FINISH) |-> stat.out_free)
        else $error("result overwrote pending transaction");

    // Element index stays within the configured order during loops
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOT_MUL || state_reg == S_LOW_MUL) |-> ({1'b0, idx_reg} < 3'(ORDER)))
        else $error("element index out of range");
`endif

endmodule

@@ rtl/linear_ode_euler_stepper.sv @@
// Top level: forward Euler stepper for a linear ODE in companion form, Q16.16.
// A load transaction leaves the block idle, so it keeps accepting input.
// A step transaction runs the dot product, the division and the element updates before the
// next input is accepted; m_tvalid rises when the step finishes, later while the previous
// result waits on m_tready. A step with a zero top coefficient goes straight to the finish.
// The rate is set by the 48-iteration restoring divider and the single shared multiplier.
// Reset (rst_n low, async) clears the state elements and x and restores register defaults.
module linear_ode_euler_stepper
    import lode_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // element_index[1:0], load_value[33:2], zero pad
    input  logic [1:0]           s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // x_value[31:0], y_value[63:32], status[65:64], pad
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [RES_W-1:0] res_data;

    lode_ctrl #(
        .ORDER(ORDER)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .operation(s_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    lode_dp #(
        .ORDER(ORDER)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .element_index(s_tdata[1:0]),
        .load_value   (s_tdata[33:2]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (res_data)
    );

    // Pad result to whole bytes
    assign m_tdata = {{(M_DATA_W - RES_W){1'b0}}, res_data};

endmodule

@@ sim/tb_linear_ode_euler_stepper.sv @@
// Self-checking testbench for the Q16.16 forward Euler linear ODE stepper.
module tb_linear_ode_euler_stepper;
    import lode_pkg::*;

    localparam int ORDER         = ORDER_DEFAULT;
    localparam int STEP_LATENCY  = 4 * ORDER + 52;
    localparam int SETTLE_CYCLES = STEP_LATENCY + 12;
    localparam int HOLD_CYCLES   = 6 * STEP_LATENCY;
    localparam int PHASE_ITEMS   = 180;
    localparam int NUM_PHASES    = 6;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 200;

    // Codes the package leaves out
    localparam logic [1:0]           OP_UNUSED       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  status;
    } step_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [1:0]           op;
        logic [1:0]           idx;
        logic [31:0]          value;
        logic                 pinned;
        step_res_t            res;
    } dir_row_t;

    localparam step_res_t NO_RES   = '0;
    localparam int        DIR_ROWS = 32;

    // Directed stimulus; pinned rows carry a hand-typed result (x, y, status)
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // fresh out of reset: everything zero, x advances by the default dx
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b1, '{32'h0, 32'h0, ST_OK}},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b1, '{32'd6554, 32'h0, ST_OK}},
        // x at its maximum saturates on advance
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_X, 2'd0, 32'h7fffffff, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b1,
          '{32'h7fffffff, 32'h0, ST_SAT}},
        // state at the extremes saturates the lower update
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_X, 2'd0, 32'h80000000, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd0, 32'h7fffffff, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd1, 32'h7fffffff, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd2, 32'h80000000, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd3, 32'h80000000, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b1,
          '{32'h80000000, 32'h7fffffff, ST_SAT}},
        // unused operation code is dropped
        '{ROW_ITEM, REG_STEP_SIZE, OP_UNUSED, 2'd1, 32'hdeadbeef, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b0, NO_RES},
        // zero divisor: state held, x saturates silently
        '{ROW_CFG, REG_COEFF_TOP, OP_LOAD_ELEM, 2'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd0, 32'h12345678, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_X, 2'd0, 32'h7fffffff, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b1,
          '{32'h7fffffff, 32'h12345678, ST_TOP_ZERO}},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b1,
          '{32'h7fffffff, 32'h12345678, ST_TOP_ZERO}},
        // writes to unmapped indexes must not land anywhere
        '{ROW_CFG, REG_SPARE_SIX, OP_LOAD_ELEM, 2'd0, 32'hffffffff, 1'b0, NO_RES},
        '{ROW_CFG, REG_SPARE_SEVEN, OP_LOAD_ELEM, 2'd0, 32'h0, 1'b0, NO_RES},
        // extreme coefficients and dx
        '{ROW_CFG, REG_COEFF_ZERO, OP_LOAD_ELEM, 2'd0, 32'h7fffffff, 1'b0, NO_RES},
        '{ROW_CFG, REG_COEFF_ONE, OP_LOAD_ELEM, 2'd0, 32'h80000000, 1'b0, NO_RES},
        '{ROW_CFG, REG_COEFF_TWO, OP_LOAD_ELEM, 2'd0, 32'h00000001, 1'b0, NO_RES},
        '{ROW_CFG, REG_COEFF_THREE, OP_LOAD_ELEM, 2'd0, 32'hffff0000, 1'b0, NO_RES},
        '{ROW_CFG, REG_COEFF_TOP, OP_LOAD_ELEM, 2'd0, 32'h80000000, 1'b0, NO_RES},
        '{ROW_CFG, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd0, 32'h80000000, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd3, 32'h00010000, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b0, NO_RES},
        // tiny negative divisor drives the quotient into saturation
        '{ROW_CFG, REG_STEP_SIZE, OP_LOAD_ELEM, 2'd0, 32'h7fffffff, 1'b0, NO_RES},
        '{ROW_CFG, REG_COEFF_TOP, OP_LOAD_ELEM, 2'd0, 32'hffffffff, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, REG_STEP_SIZE, OP_STEP, 2'd0, 32'h0, 1'b0, NO_RES}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]       cfg_data;

    // Hand-typed expectation travelling with the current transaction
    logic                 pin_en;
    step_res_t            pin_res;

    // Predictor copy of the block's state and registers
    logic signed [31:0]   elem [NUM_ELEM];
    logic signed [31:0]   cur_x;
    logic signed [31:0]   dx;
    logic signed [31:0]   coef [4];
    logic signed [31:0]   coef_top;
    bit                   sat_seen;

    step_res_t            pending_results [$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    int                   send_idle_pct  = 0;
    int                   recv_idle_pct  = 0;
    bit                   hold_req       = 1'b0;
    bit                   hold_done      = 1'b0;

    linear_ode_euler_stepper #(.ORDER(ORDER)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Clamp to the Q16.16 range, noting any saturation
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > Q_MAX)
        begin
            sat_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < Q_MIN)
        begin
            sat_seen = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Exact product, low fraction bits dropped (floor)
    function automatic longint qprod(input logic signed [31:0] a, input logic signed [31:0] b);
        return (longint'(a) * longint'(b)) >>> 16;
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < NUM_ELEM; i++)
            elem[i] = '0;
        for (int i = 0; i < 4; i++)
            coef[i] = '0;
        cur_x    = '0;
        dx       = STEP_SIZE_RST;
        coef_top = COEFF_TOP_RST;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
        case (idx)
            REG_STEP_SIZE:   dx       = data;
            REG_COEFF_ZERO:  coef[0]  = data;
            REG_COEFF_ONE:   coef[1]  = data;
            REG_COEFF_TWO:   coef[2]  = data;
            REG_COEFF_THREE: coef[3]  = data;
            REG_COEFF_TOP:   coef_top = data;
            default:         ;
        endcase
    endfunction

    // Apply one input transaction; returns 1 with the result for a step
    function automatic bit euler_predict(input logic [1:0] op, input logic [1:0] idx,
                                         input logic signed [31:0] val,
                                         output step_res_t res);
        logic signed [31:0] nxt [NUM_ELEM];
        logic signed [31:0] inc;
        logic signed [31:0] acc32;
        logic signed [31:0] q32;
        longint             acc;
        res = '0;
        if (op == OP_LOAD_ELEM)
        begin
            if (int'(idx) < ORDER)
                elem[idx] = val;
            return 1'b0;
        end
        if (op == OP_LOAD_X)
        begin
            cur_x = val;
            return 1'b0;
        end
        if (op != OP_STEP)
            return 1'b0;

        res.x    = cur_x;
        res.y    = elem[0];
        sat_seen = 1'b0;
        if (coef_top == 0)
        begin
            // state held; x saturation does not change the status
            cur_x      = clamp32(longint'(cur_x) + longint'(dx));
            res.status = ST_TOP_ZERO;
            return 1'b1;
        end

        for (int i = 0; i < NUM_ELEM; i++)
            nxt[i] = elem[i];
        // lower elements integrate the next one up
        for (int i = 0; i < ORDER - 1; i++)
        begin
            inc    = clamp32(qprod(dx, elem[i + 1]));
            nxt[i] = clamp32(longint'(elem[i]) + longint'(inc));
        end
        // top element: dot product over the negated top coefficient
        acc = 0;
        for (int i = 0; i < ORDER; i++)
            acc += qprod(coef[i], elem[i]);
        acc32          = clamp32(acc);
        q32            = clamp32((longint'(acc32) * 65536) / (-longint'(coef_top)));
        inc            = clamp32(qprod(dx, q32));
        nxt[ORDER - 1] = clamp32(longint'(elem[ORDER - 1]) + longint'(inc));
        for (int i = 0; i < NUM_ELEM; i++)
            elem[i] = nxt[i];
        cur_x      = clamp32(longint'(cur_x) + longint'(dx));
        res.status = sat_seen ? ST_SAT : ST_OK;
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $error("%s: expected %h, got %h", field, want, got);
    endfunction

    // Scoreboard: check outgoing results, then predict incoming transactions
    always @(posedge clk)
    begin : scoreboard
        step_res_t got;
        step_res_t want;
        step_res_t pred;
        bit        has_res;
        if (!rst_n)
            reset_predictor();
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.x      = m_tdata[31:0];
                got.y      = m_tdata[63:32];
                got.status = m_tdata[65:64];
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result x_value", 32'h0, got.x);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.x !== want.x)
                        report_mismatch("x_value", want.x, got.x);
                    if (got.y !== want.y)
                        report_mismatch("y_value", want.y, got.y);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                end
            end
            if (cfg_we)
                apply_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                has_res = euler_predict(s_tuser, s_tdata[1:0], s_tdata[33:2], pred);
                if (has_res)
                    pending_results.insert(pending_results.size(), pin_en ? pin_res : pred);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random backpressure, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one transaction, with random idle cycles before it
    task automatic send_item(input logic [1:0] op, input logic [1:0] idx,
                             input logic [31:0] val, input logic pinned,
                             input step_res_t res);
        cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - 34){1'b0}}, val, idx};
        pin_en   <= pinned;
        pin_res  <= res;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drain all results, then let an in-flight item finish
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        // let the scoreboard queue the last accepted transaction first
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return 32'($urandom_range(262143)) - 32'd131072;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return 32'($urandom_range(32767)) - 32'd16384;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(524287)) - 32'd262144;
        endcase
    endfunction

    // Stimulus
    initial
    begin : stimulus
        logic [1:0]  op;
        logic [1:0]  idx;
        logic [31:0] val;
        int          counted;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pin_en    = 1'b0;
        pin_res   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        send_idle_pct = 7;
        recv_idle_pct = 54;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TABLE[r].kind == ROW_CFG)
            begin
                wait_until_idle();
                cfg_write(DIR_TABLE[r].reg_idx, DIR_TABLE[r].value);
            end
            else
                send_item(DIR_TABLE[r].op, DIR_TABLE[r].idx, DIR_TABLE[r].value,
                          DIR_TABLE[r].pinned, DIR_TABLE[r].res);
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_until_idle();
            if (ph < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 54;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cfg_write(REG_STEP_SIZE, pick_step());
            cfg_write(REG_COEFF_ZERO, pick_coeff());
            cfg_write(REG_COEFF_ONE, pick_coeff());
            cfg_write(REG_COEFF_TWO, pick_coeff());
            cfg_write(REG_COEFF_THREE, pick_coeff());
            cfg_write(REG_COEFF_TOP, ($urandom_range(7) == 0) ? 32'h0 : pick_coeff());

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                // result side stalls for a long stretch while steps keep coming
                if (ph == 4 && counted == 40)
                    hold_req = 1'b1;
                // sender stops until the block has drained
                if (ph == 2 && counted == 100)
                    wait_until_idle();
                case ($urandom_range(99)) inside
                    [0:44]:  op = OP_STEP;
                    [45:79]: op = OP_LOAD_ELEM;
                    [80:94]: op = OP_LOAD_X;
                    default: op = OP_UNUSED;
                endcase
                idx = 2'($urandom_range(3));
                val = pick_value();
                send_item(op, idx, val, 1'b0, NO_RES);
                if (op != OP_UNUSED && !(op == OP_LOAD_ELEM && int'(idx) >= ORDER))
                    counted++;
            end
        end

        wait_until_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
